/* rtl/core/iaes128_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Iterated AES-128 encryptor package
// Shared types, constants and the AES round function used by the encryptor.
// ----------------------------------------------------------------------------
package iaes128_pkg;

    // Default number of round keys in an expanded AES-128 schedule.
    localparam int RKC_DEFAULT = 11;

    // Widths fixed by the item fields.
    localparam int KEY_IDX_W  = 5;
    localparam int WORD_W     = 64;
    localparam int COUNT_W    = 32;
    localparam int BLOCK_W    = 128;
    localparam int BLOCK_BYTES = 16;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [7:0]         t_byte;

    localparam t_byte SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Multiplication by x in GF(2^8) with the AES polynomial.
    function automatic t_byte xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
    // Byte 0 is in the top bits; byte r + 4*c is row r of column c.
    function automatic t_block aes_round(input t_block s, input t_block k, input logic mix);
        t_byte  t [BLOCK_BYTES];
        t_byte  m [BLOCK_BYTES];
        t_byte  a0, a1, a2, a3;
        t_block res;
        int     r, c, i;
        for (c = 0; c < 4; c++) begin
            for (r = 0; r < 4; r++) begin
                t[r + 4*c] = SBOX[s[8*(15 - (r + 4*((c + r) & 3))) +: 8]];
            end
        end
        for (c = 0; c < 4; c++) begin
            a0 = t[4*c];
            a1 = t[4*c + 1];
            a2 = t[4*c + 2];
            a3 = t[4*c + 3];
            m[4*c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            m[4*c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            m[4*c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            m[4*c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        for (i = 0; i < BLOCK_BYTES; i++) begin
            res[8*(15 - i) +: 8] = (mix ? m[i] : t[i]) ^ k[8*(15 - i) +: 8];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/iterated_aes128_encrypt_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Encrypt items are handled one at a time: a new item is accepted only while the sequencer
// is idle. The single round unit does one round key per cycle, and a result still waiting
// in the output register holds the next one back.
// Reset (synchronous, active low) clears the sequencer and output valid and sets the
// iteration count to 1; the round key memory keeps no reset value and must be loaded.
// ----------------------------------------------------------------------------
// Iterated AES-128 encryptor
// Applies AES-128 encryption to a block a configurable number of times using a
// loaded round key schedule and one shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
module iterated_aes128_encrypt_top
    import iaes128_pkg::*;
#(
    parameter int ROUND_KEY_COUNT = RKC_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write channel: the iteration count register.
    input  wire logic                 i_cfg_valid,
    output      logic                 o_cfg_ready,
    input  wire logic [COUNT_W-1:0]   i_cfg_data,
    // Input item channel.
    input  wire logic                 i_valid,
    output      logic                 o_ready,
    input  wire logic                 i_cmd,
    input  wire logic [KEY_IDX_W-1:0] i_key_word_index,
    input  wire logic [WORD_W-1:0]    i_key_word,
    input  wire logic [WORD_W-1:0]    i_block_high,
    input  wire logic [WORD_W-1:0]    i_block_low,
    // Result item channel.
    output      logic                 o_valid,
    input  wire logic                 i_ready,
    output      logic [WORD_W-1:0]    o_result_high,
    output      logic [WORD_W-1:0]    o_result_low
);

    // Width of a round key number; also addresses the two key memories.
    localparam int RW = $clog2(ROUND_KEY_COUNT);
    localparam logic [RW-1:0]        LAST_ROUND = RW'(ROUND_KEY_COUNT - 1);
    localparam logic [KEY_IDX_W-1:0] KEY_WORDS  = KEY_IDX_W'(2 * ROUND_KEY_COUNT);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ENC  = 1'b1;

    // The round key schedule lives in two memories, one for the high half of
    // each round key and one for the low half, so that a whole round key is
    // read at a single address every cycle.
    logic [WORD_W-1:0] mem_hi [ROUND_KEY_COUNT];
    logic [WORD_W-1:0] mem_lo [ROUND_KEY_COUNT];

    logic [1:0]         r_state;
    logic [RW-1:0]      r_round;
    logic [COUNT_W-1:0] r_iter_count;
    logic [COUNT_W-1:0] r_iter_left;
    t_block             r_blk;
    t_block             r_key;
    logic               r_out_valid;
    t_block             r_out;

    logic               in_fire;
    logic               key_wr;
    logic [RW-1:0]      key_row;
    logic [RW-1:0]      rd_addr;
    logic               out_free;
    t_block             round_out;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign in_fire     = i_valid && o_ready;
    assign key_wr      = in_fire && (i_cmd == CMD_LOAD) && (i_key_word_index < KEY_WORDS);
    assign key_row     = i_key_word_index[RW:1];
    assign out_free    = !r_out_valid || i_ready;

    // The address of the round key needed in the next cycle. Key 0 is fetched
    // while idle and again while the last round of an iteration runs, so the
    // next iteration starts its whitening step without a gap.
    always_comb begin
        rd_addr = '0;
        if (r_state == ST_RUN && r_round != LAST_ROUND) begin
            rd_addr = RW'(r_round + 1'b1);
        end
    end

    // Round key memories: one write port, registered read.
    always_ff @(posedge i_clk) begin
        if (key_wr && !i_key_word_index[0]) begin
            mem_hi[key_row] <= i_key_word;
        end
        if (key_wr && i_key_word_index[0]) begin
            mem_lo[key_row] <= i_key_word;
        end
        r_key <= {mem_hi[rd_addr], mem_lo[rd_addr]};
    end

    // The shared round unit. Round 0 is the whitening step, the last round
    // skips MixColumns, and all others are full rounds.
    always_comb begin
        if (r_round == '0) begin
            round_out = r_blk ^ r_key;
        end else begin
            round_out = aes_round(r_blk, r_key, r_round != LAST_ROUND);
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter_count <= COUNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_iter_count <= i_cfg_data;
        end
    end

    // Sequencer and control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register empties when its item is taken. While the
            // sequencer is done it decides the output valid on its own.
            if (r_out_valid && i_ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire && i_cmd == CMD_ENC) begin
                        r_round <= '0;
                        // A zero count passes the block through unchanged.
                        r_state <= (r_iter_count == '0) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_round == LAST_ROUND) begin
                        r_round <= '0;
                        if (r_iter_left == COUNT_W'(1)) begin
                            r_state <= ST_DONE;
                        end
                    end else begin
                        r_round <= RW'(r_round + 1'b1);
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_fire && i_cmd == CMD_ENC) begin
                    r_blk       <= {i_block_high, i_block_low};
                    r_iter_left <= r_iter_count;
                end
            end
            ST_RUN: begin
                r_blk <= round_out;
                if (r_round == LAST_ROUND) begin
                    r_iter_left <= r_iter_left - COUNT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out <= r_blk;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_result_high = r_out[BLOCK_W-1:WORD_W];
    assign o_result_low  = r_out[WORD_W-1:0];

endmodule
`default_nettype wire

/* tb/sv/iterated_aes128_encrypt_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterated AES-128 encryptor testbench
// Loads round key schedules, sets the iteration count and pushes plaintext
// items through the encryptor under random valid/ready gaps. A local cipher
// model, built from the GF(2^8) arithmetic up, predicts each ciphertext, and
// every result item is checked in order against it.
// ----------------------------------------------------------------------------
module iterated_aes128_encrypt_top_test;
    import iaes128_pkg::*;

    localparam int ROUND_KEY_TOTAL = RKC_DEFAULT;
    localparam int KEY_WORDS       = 2 * ROUND_KEY_TOTAL;
    localparam int PHASE_ITEMS     = 135;
    localparam int CYCLE_LIMIT     = 1_000_000;

    // Command encoding of the input item.
    typedef enum logic {
        CMD_LOAD_KEY = 1'b0,
        CMD_ENCRYPT  = 1'b1
    } cmd_e;

    typedef logic [WORD_W-1:0] key_sched_t [KEY_WORDS];

    // Clock, reset and every block input start at a known value.
    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_valid      = 1'b0;
    logic [COUNT_W-1:0]   i_cfg_data       = '0;
    logic                 i_valid          = 1'b0;
    logic                 i_cmd            = 1'b0;
    logic [KEY_IDX_W-1:0] i_key_word_index = '0;
    logic [WORD_W-1:0]    i_key_word       = '0;
    logic [WORD_W-1:0]    i_block_high     = '0;
    logic [WORD_W-1:0]    i_block_low      = '0;
    logic                 i_ready          = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_ready;
    logic                 o_valid;
    logic [WORD_W-1:0]    o_result_high;
    logic [WORD_W-1:0]    o_result_low;

    // Local copy of what the encryptor holds: the key store and the count.
    logic [WORD_W-1:0]  key_store [KEY_WORDS];
    logic [COUNT_W-1:0] iter_count = 32'd1;
    t_byte              sub_table [256];

    // Ciphertexts still owed by the encryptor, oldest first.
    t_block expected_ciphertext_q [$];
    t_block oldest_ciphertext;

    int          fault_count    = 0;
    int          counted_items  = 0;
    int          tx_idle_pct    = 37;
    int          rx_idle_pct    = 37;
    int          rx_hold_left   = 0;
    int unsigned cycle_count    = 0;

    iterated_aes128_encrypt_top #(
        .ROUND_KEY_COUNT (ROUND_KEY_TOTAL)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_key_word_index (i_key_word_index),
        .i_key_word       (i_key_word),
        .i_block_high     (i_block_high),
        .i_block_low      (i_block_low),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_high    (o_result_high),
        .o_result_low     (o_result_low)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a run that hangs ends with an error report.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("iterated_aes128_encrypt_top_test: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Cipher model
    // ------------------------------------------------------------------------

    // Product in GF(2^8) reduced by the AES polynomial x^8 + x^4 + x^3 + x + 1.
    function automatic t_byte gf_times(t_byte a, t_byte b);
        t_byte p;
        t_byte x;
        t_byte y;
        int    n;
        p = 8'h00;
        x = a;
        y = b;
        for (n = 0; n < 8; n++) begin
            if (y[0]) p ^= x;
            x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
            y = y >> 1;
        end
        return p;
    endfunction

    // The S-box is derived rather than copied: multiplicative inverse (as
    // x^254, which also maps zero to zero) followed by the affine transform.
    function automatic void build_sub_table();
        t_byte inv;
        t_byte pw;
        int    x;
        int    e;
        for (x = 0; x < 256; x++) begin
            inv = 8'h01;
            pw  = x[7:0];
            e   = 254;
            while (e != 0) begin
                if (e[0]) inv = gf_times(inv, pw);
                pw = gf_times(pw, pw);
                e  = e >> 1;
            end
            sub_table[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                         ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    endfunction

    // One round on a block whose byte 0 sits in the top bits. Byte r + 4*c
    // is row r of column c, so ShiftRows pulls row r from column c + r.
    function automatic t_block cipher_round(t_block s, t_block rkey, bit mix);
        t_byte  st [16];
        t_byte  sh [16];
        t_byte  a0, a1, a2, a3;
        t_block res;
        int     n, row, col;
        for (n = 0; n < 16; n++) st[n] = s[127 - 8*n -: 8];
        for (col = 0; col < 4; col++) begin
            for (row = 0; row < 4; row++) begin
                sh[row + 4*col] = sub_table[st[row + 4*((col + row) % 4)]];
            end
        end
        if (mix) begin
            for (col = 0; col < 4; col++) begin
                a0 = sh[4*col];
                a1 = sh[4*col + 1];
                a2 = sh[4*col + 2];
                a3 = sh[4*col + 3];
                sh[4*col]     = gf_times(a0, 8'h02) ^ gf_times(a1, 8'h03) ^ a2 ^ a3;
                sh[4*col + 1] = a0 ^ gf_times(a1, 8'h02) ^ gf_times(a2, 8'h03) ^ a3;
                sh[4*col + 2] = a0 ^ a1 ^ gf_times(a2, 8'h02) ^ gf_times(a3, 8'h03);
                sh[4*col + 3] = gf_times(a0, 8'h03) ^ a1 ^ a2 ^ gf_times(a3, 8'h02);
            end
        end
        for (n = 0; n < 16; n++) res[127 - 8*n -: 8] = sh[n] ^ rkey[127 - 8*n -: 8];
        return res;
    endfunction

    // Full iterated encryption with the current key store and count.
    function automatic t_block predict_ciphertext(t_block plain);
        t_block          s;
        longint unsigned pass;
        int              r;
        s = plain;
        for (pass = 0; pass < iter_count; pass++) begin
            s ^= {key_store[0], key_store[1]};
            for (r = 1; r < ROUND_KEY_TOTAL - 1; r++) begin
                s = cipher_round(s, {key_store[2*r], key_store[2*r + 1]}, 1'b1);
            end
            s = cipher_round(s, {key_store[KEY_WORDS - 2], key_store[KEY_WORDS - 1]}, 1'b0);
        end
        return s;
    endfunction

    // Standard AES-128 key expansion, returned as high/low 64-bit halves.
    function automatic key_sched_t expand_key(t_block cipher_key);
        logic [31:0] w [4*ROUND_KEY_TOTAL];
        logic [31:0] tmp;
        t_byte       rcon;
        key_sched_t  sched;
        int          i;
        rcon = 8'h01;
        for (i = 0; i < 4; i++) w[i] = cipher_key[127 - 32*i -: 32];
        for (i = 4; i < 4*ROUND_KEY_TOTAL; i++) begin
            tmp = w[i - 1];
            if (i % 4 == 0) begin
                tmp = {sub_table[tmp[23:16]] ^ rcon, sub_table[tmp[15:8]],
                       sub_table[tmp[7:0]], sub_table[tmp[31:24]]};
                rcon = gf_times(rcon, 8'h02);
            end
            w[i] = w[i - 4] ^ tmp;
        end
        for (i = 0; i < KEY_WORDS; i++) sched[i] = {w[2*i], w[2*i + 1]};
        return sched;
    endfunction

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    function automatic void note_fault(string what, t_block want, t_block got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("MISMATCH %s: expected %h %h, got %h %h", what,
                     want[127:64], want[63:0], got[127:64], got[63:0]);
        end
    endfunction

    // The receiver drops ready at random, or for a counted hold-off when a
    // test loads rx_hold_left.
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Every accepted result item is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_ciphertext_q.size() == 0) begin
                note_fault("result item with none outstanding", 'x,
                           {o_result_high, o_result_low});
            end else begin
                oldest_ciphertext = expected_ciphertext_q.pop_front();
                if (o_result_high !== oldest_ciphertext[127:64]
                        || o_result_low !== oldest_ciphertext[63:0]) begin
                    note_fault("ciphertext", oldest_ciphertext,
                               {o_result_high, o_result_low});
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Offers one item and returns at the edge where it is taken. Valid is
    // only lowered during a chosen gap, so back-to-back items keep it high.
    task automatic send_item(cmd_e cmd, logic [KEY_IDX_W-1:0] idx,
                             logic [WORD_W-1:0] kword, t_block blk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_cmd            <= cmd;
        i_key_word_index <= idx;
        i_key_word       <= kword;
        i_block_high     <= blk[127:64];
        i_block_low      <= blk[63:0];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (cmd == CMD_ENCRYPT) begin
            expected_ciphertext_q.push_back(predict_ciphertext(blk));
            counted_items++;
        end else if (idx < KEY_WORDS) begin
            key_store[idx] = kword;
            counted_items++;
        end
    endtask

    // Block fields ride along with random content on a key load, and the
    // key fields likewise on an encrypt.
    task automatic send_key_word(logic [KEY_IDX_W-1:0] idx, logic [WORD_W-1:0] kword);
        send_item(CMD_LOAD_KEY, idx, kword, {random_word(), random_word()});
    endtask

    task automatic send_block(t_block blk);
        send_item(CMD_ENCRYPT, KEY_IDX_W'($urandom_range(31)), random_word(), blk);
    endtask

    // Loads a whole schedule with the words in shuffled order.
    task automatic load_schedule(key_sched_t sched);
        int order [$];
        int pick;
        int n;
        for (n = 0; n < KEY_WORDS; n++) order.push_back(n);
        while (order.size() != 0) begin
            pick = $urandom_range(order.size() - 1);
            send_key_word(KEY_IDX_W'(order[pick]), sched[order[pick]]);
            order.delete(pick);
        end
    endtask

    // Lowers valid and waits until every owed result has come back; the short
    // pause afterwards covers a key load still settling, which owes nothing.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_ciphertext_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_iter_count(logic [COUNT_W-1:0] count);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        iter_count = count;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Known answer from the AES standard, run at the reset iteration count of
    // one. The local model is held to the published ciphertext first, so a
    // fault in the model itself shows up here rather than as noise later.
    task automatic test_fips_vector();
        t_block plain;
        t_block known;
        plain = 128'h00112233445566778899aabbccddeeff;
        known = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
        load_schedule(expand_key(128'h000102030405060708090a0b0c0d0e0f));
        if (predict_ciphertext(plain) !== known) begin
            note_fault("cipher model against known answer", known, predict_ciphertext(plain));
        end
        send_block(plain);
    endtask

    task automatic test_special_cases();
        // Key indexes past the end of the store must leave it untouched.
        send_key_word(KEY_IDX_W'(KEY_WORDS), random_word());
        send_key_word(5'd31, random_word());
        send_block({2{64'hffff_ffff_ffff_ffff}});
        // Extreme key word values at both ends of the store.
        send_key_word(5'd0, 64'hffff_ffff_ffff_ffff);
        send_key_word(KEY_IDX_W'(KEY_WORDS - 1), 64'h0);
        send_block('0);
        // A zero count hands the block back unchanged.
        write_iter_count(32'd0);
        send_block({random_word(), random_word()});
        send_block({2{64'hffff_ffff_ffff_ffff}});
        // The all-ones count would take far too long per block; it is written
        // to move every register bit and then replaced while still idle.
        write_iter_count(32'hffff_ffff);
        write_iter_count(32'd1);
    endtask

    // Mostly well-formed traffic: schedules loaded whole and followed by runs
    // of blocks, with single word rewrites and ignored loads mixed in.
    task automatic test_random_traffic();
        logic [COUNT_W-1:0] phase_counts [7];
        int                 phase;
        int                 first_item;
        int                 pick;
        int                 n;
        key_sched_t         sched;
        phase_counts = '{32'd2, 32'd1, 32'd0, 32'd3, 32'd1, 32'd5, 32'd2};
        for (phase = 0; phase < 7; phase++) begin
            write_iter_count(phase_counts[phase]);
            first_item = counted_items;
            while (counted_items - first_item < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    if ($urandom_range(1) == 1) begin
                        sched = expand_key({random_word(), random_word()});
                    end else begin
                        for (n = 0; n < KEY_WORDS; n++) sched[n] = random_word();
                    end
                    load_schedule(sched);
                end else if (pick < 14) begin
                    send_key_word(KEY_IDX_W'($urandom_range(KEY_WORDS - 1)), random_word());
                end else if (pick < 18) begin
                    send_key_word(KEY_IDX_W'($urandom_range(31, KEY_WORDS)), random_word());
                end else begin
                    repeat ($urandom_range(6, 1)) send_block({random_word(), random_word()});
                end
            end
        end
    endtask

    // A large count, with only a couple of blocks since each runs through every
    // iteration.
    task automatic test_long_iterations();
        write_iter_count(32'd1000);
        repeat (2) send_block({random_word(), random_word()});
        write_iter_count(32'd1);
    endtask

    // Back-to-back traffic with neither side ever idling.
    task automatic test_no_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (60) begin
            if ($urandom_range(9) == 0) begin
                send_key_word(KEY_IDX_W'($urandom_range(KEY_WORDS - 1)), random_word());
            end
            send_block({random_word(), random_word()});
        end
        wait_idle();
        tx_idle_pct = 37;
        rx_idle_pct = 37;
    endtask

    // The receiver holds off for a long stretch while blocks keep coming, so
    // the encryptor fills up and has to stall its input.
    task automatic test_input_backpressure();
        write_iter_count(32'd2);
        tx_idle_pct  = 0;
        rx_hold_left <= 400;
        repeat (8) send_block({random_word(), random_word()});
        tx_idle_pct = 37;
        wait_idle();
    endtask

    initial begin
        build_sub_table();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fips_vector();
        test_special_cases();
        test_random_traffic();
        test_long_iterations();
        test_no_idle();
        test_input_backpressure();

        // Drain, then linger a little so a stray extra result is caught.
        wait_idle();
        repeat (50) @(posedge i_clk);
        if (fault_count == 0 && expected_ciphertext_q.size() == 0) begin
            $display("iterated_aes128_encrypt_top_test: done, clean");
        end else begin
            $display("iterated_aes128_encrypt_top_test: done, errors");
        end
        $finish;
    end

endmodule

/* iterated_aes128_encrypt_top.f */
rtl/core/iaes128_pkg.sv
rtl/core/iterated_aes128_encrypt_top.sv
tb/sv/iterated_aes128_encrypt_top_test.sv
